// File: src/sraf_pkg.sv
// Shared types, character codes and scaling constants for the sensor reading framer.
// Used by sraf_scale, sraf_fmt, sraf_ser and the top level; depends on nothing.

package sraf_pkg;

	localparam int unsigned LINE_BYTES = 16;
	localparam int unsigned IDX_W      = $clog2(LINE_BYTES);

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [7:0] TEMP_ZERO = 8'd69;

	// Reciprocal products: code*100/51 == (code*2056100) >> 20,
	// y*150/186 == (y*211425) >> 18 and y*55/69 == (y*209000) >> 18 for the input ranges.
	localparam logic [21:0] VOLT_RECIP     = 22'd2056100;
	localparam int unsigned VOLT_SHIFT     = 20;
	localparam logic [17:0] TEMP_POS_RECIP = 18'd211425;
	localparam logic [17:0] TEMP_NEG_RECIP = 18'd209000;
	localparam int unsigned TEMP_SHIFT     = 18;

	typedef struct packed {
		logic [7:0] cnt;
		logic [8:0] volt;
		logic [7:0] temp;
		logic       neg;
	} scaled_t;

	typedef logic [LINE_BYTES-1:0][7:0] line_t;
	typedef logic [2:0][3:0] dec3_t;

	// Three decimal digits of a 9-bit value (below 512), hundreds in entry 2.
	function automatic dec3_t dec3(input logic [8:0] v);
		logic [14:0] ph;
		logic [16:0] pt;
		logic [2:0]  h;
		logic [5:0]  q10;
		logic [5:0]  t;
		logic [8:0]  u;
		dec3_t       d;
		ph  = 15'({6'd0, v} * 15'd41);
		h   = ph[14:12];
		pt  = 17'({8'd0, v} * 17'd205);
		q10 = pt[16:11];
		t   = 6'(q10 - 6'({3'd0, h} * 6'd10));
		u   = 9'(v - 9'({3'd0, q10} * 9'd10));
		d[2] = {1'b0, h};
		d[1] = t[3:0];
		d[0] = u[3:0];
		return d;
	endfunction

	function automatic logic [7:0] ascii_digit(input logic [3:0] d);
		return 8'(CH_ZERO + {4'd0, d});
	endfunction

endpackage

// File: src/sraf_scale.sv
// Input register and scaling stage: voltage hundredths and signed temperature.
// Depends on sraf_pkg for the scaled value struct and reciprocal constants.

module sraf_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       cnt_in,
	input  logic [7:0]       volt_in,
	input  logic [7:0]       temp_in,
	output logic             out_valid,
	input  logic             out_ready,
	output sraf_pkg::scaled_t out_val
);
	import sraf_pkg::*;

	logic       valid_s1;
	logic       valid_s2;
	logic [7:0] cnt_s1;
	logic [7:0] volt_s1;
	logic [7:0] temp_s1;
	scaled_t    val_s2;

	logic        s2_free;
	logic        s1_adv;
	logic        temp_pos;
	logic [7:0]  temp_dist;
	logic [17:0] temp_recip;
	logic [29:0] volt_prod;
	logic [25:0] temp_prod;
	scaled_t     val_next;

	assign s2_free  = !valid_s2 || out_ready;
	assign s1_adv   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_comb begin
		temp_pos   = (temp_s1 >= TEMP_ZERO);
		temp_dist  = temp_pos ? 8'(temp_s1 - TEMP_ZERO) : 8'(TEMP_ZERO - temp_s1);
		temp_recip = temp_pos ? TEMP_POS_RECIP : TEMP_NEG_RECIP;
		volt_prod  = 30'({22'd0, volt_s1} * {8'd0, VOLT_RECIP});
		temp_prod  = 26'({18'd0, temp_dist} * {8'd0, temp_recip});
		val_next.cnt  = cnt_s1;
		val_next.volt = volt_prod[VOLT_SHIFT +: 9];
		val_next.temp = temp_prod[TEMP_SHIFT +: 8];
		val_next.neg  = !temp_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && in_ready) || (valid_s1 && !s2_free);
			valid_s2 <= s1_adv || (valid_s2 && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cnt_s1  <= cnt_in;
			volt_s1 <= volt_in;
			temp_s1 <= temp_in;
		end
		if (s1_adv) begin
			val_s2 <= val_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_val   = val_s2;

endmodule

// File: src/sraf_fmt.sv
// Line formatter: turns scaled readings into the sixteen ASCII characters of a line.
// Depends on sraf_pkg for the decimal split and character codes.

module sraf_fmt (
	input  sraf_pkg::scaled_t val,
	output sraf_pkg::line_t   line
);
	import sraf_pkg::*;

	dec3_t cnt_d;
	dec3_t volt_d;
	dec3_t temp_d;

	always_comb begin
		cnt_d  = dec3({1'b0, val.cnt});
		volt_d = dec3(val.volt);
		temp_d = dec3({1'b0, val.temp});
		line[0]  = ascii_digit(cnt_d[2]);
		line[1]  = ascii_digit(cnt_d[1]);
		line[2]  = ascii_digit(cnt_d[0]);
		line[3]  = CH_COMMA;
		line[4]  = CH_SPACE;
		line[5]  = ascii_digit(volt_d[2]);
		line[6]  = CH_DOT;
		line[7]  = ascii_digit(volt_d[1]);
		line[8]  = ascii_digit(volt_d[0]);
		line[9]  = CH_COMMA;
		line[10] = CH_SPACE;
		line[11] = val.neg ? CH_MINUS : CH_SPACE;
		line[12] = ascii_digit(temp_d[2]);
		line[13] = ascii_digit(temp_d[1]);
		line[14] = ascii_digit(temp_d[0]);
		line[15] = CH_CR;
	end

endmodule

// File: src/sraf_ser.sv
// Line serializer: holds one formatted line and shifts it out one word per handshake.
// Depends on sraf_pkg for the line type and its length.

module sraf_ser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sraf_pkg::line_t line,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);
	import sraf_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	line_t            line_q;

	logic take;
	logic last;

	assign last      = (idx_q == IDX_W'(LINE_BYTES - 1));
	assign take      = busy_q && out_ready;
	assign in_ready  = !busy_q || (take && last);
	assign out_valid = busy_q;
	assign out_byte  = line_q[0];
	assign out_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= !last;
			idx_q  <= IDX_W'(idx_q + 1'b1);
		end
	end

	// The word on the port is always the lowest byte; each handshake shifts the rest down.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			line_q <= line;
		end else if (take) begin
			line_q <= {8'd0, line_q[LINE_BYTES-1:1]};
		end
	end

endmodule

// File: src/sensor_readings_ascii_framer_unit.sv
// Top level of the sensor reading framer: scale stage, formatter and line serializer.
// Depends on sraf_pkg, sraf_scale, sraf_fmt and sraf_ser.
//
//  Port group   Dir  Word layout (lowest bit first)                Ends a word
//  s_axis       in   counter_value, voltage_code, temperature_code s_tvalid & s_tready
//  m_axis       out  tx_byte; tlast = last_of_frame                 m_tvalid & m_tready
//
// A reading set passes the input register and the scaling register, then loads the
// line register; its sixteen words follow one per cycle while m_tready is high.
// The line register sets the sustained rate: one reading set per sixteen output words.
// Two further reading sets can wait in the input and scaling registers meanwhile.
// Reset clears the valid and busy flags and the word index; stalls on m_tready hold every stage in place.

module sensor_readings_ascii_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // counter_value, voltage_code, temperature_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // tx_byte
	output logic        m_tlast
);
	import sraf_pkg::*;

	logic    scl_valid;
	logic    scl_ready;
	scaled_t scl_val;
	line_t   fmt_line;

	sraf_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cnt_in    (s_tdata[7:0]),
		.volt_in   (s_tdata[15:8]),
		.temp_in   (s_tdata[23:16]),
		.out_valid (scl_valid),
		.out_ready (scl_ready),
		.out_val   (scl_val)
	);

	sraf_fmt u_fmt (
		.val  (scl_val),
		.line (fmt_line)
	);

	sraf_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.line      (fmt_line),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	// A line that is still being sent keeps the port busy after a word that is not its last.
	a_line_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("line stopped before its carriage return");

	// A fresh line never starts on its last word.
	a_fresh_line: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !m_tlast)
		else $error("new line started on its final word");

	// The word that closes a line is the carriage return.
	a_last_is_cr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == CH_CR)
		else $error("line closed by a word other than carriage return");

endmodule

// File: tb/tb_sensor_readings_ascii_framer_unit.sv
// Self-checking testbench for sensor_readings_ascii_framer_unit.
// It needs only sraf_pkg and the RTL. Reading sets go in on s_axis, and every ASCII
// word on m_axis is checked against a line built here from the same readings.

module tb_sensor_readings_ascii_framer_unit;
	import sraf_pkg::*;

	localparam int unsigned VOLT_SCALE_MUL = 100;
	localparam int unsigned VOLT_SCALE_DIV = 51;
	localparam int unsigned WARM_MUL       = 150;
	localparam int unsigned WARM_DIV       = 186;
	localparam int unsigned COLD_MUL       = 55;
	localparam int unsigned COLD_DIV       = 69;
	localparam int unsigned RANDOM_SETS    = 300;
	localparam int unsigned LONG_HOLD      = 400;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} line_char_t;

	typedef struct packed {
		logic [23:0] data;   // temperature_code, voltage_code, counter_value
		logic        drain_first;
	} reading_t;

	typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	reading_t    readings_pending[$];
	line_char_t  line_chars_due[$];
	line_char_t  due_char;
	logic        word_in_taken;
	int unsigned readings_accepted;
	int unsigned words_checked;
	int unsigned mismatches;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned mode_left;
	int unsigned long_hold_left;
	logic        long_hold_done;
	rx_mode_t    rx_mode;
	logic [7:0]  rx_pattern;

	sensor_readings_ascii_framer_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [7:0] digit_char(input int unsigned v, input int unsigned scale);
		return 8'(CH_ZERO + 8'((v / scale) % 10));
	endfunction

	// Builds the sixteen characters that one reading set must produce.
	task automatic queue_line(input logic [7:0] cnt, input logic [7:0] vcode,
			input logic [7:0] tcode);
		int unsigned volt;
		int unsigned temp;
		logic [7:0]  sgn;
		logic [7:0]  chars [LINE_BYTES];
		line_char_t  c;
		volt = (int'(vcode) * VOLT_SCALE_MUL) / VOLT_SCALE_DIV;
		if (tcode >= TEMP_ZERO) begin
			temp = ((int'(tcode) - int'(TEMP_ZERO)) * WARM_MUL) / WARM_DIV;
			sgn  = CH_SPACE;
		end else begin
			temp = ((int'(TEMP_ZERO) - int'(tcode)) * COLD_MUL) / COLD_DIV;
			sgn  = CH_MINUS;
		end
		chars[0]  = digit_char(cnt, 100);
		chars[1]  = digit_char(cnt, 10);
		chars[2]  = digit_char(cnt, 1);
		chars[3]  = CH_COMMA;
		chars[4]  = CH_SPACE;
		chars[5]  = digit_char(volt, 100);
		chars[6]  = CH_DOT;
		chars[7]  = digit_char(volt, 10);
		chars[8]  = digit_char(volt, 1);
		chars[9]  = CH_COMMA;
		chars[10] = CH_SPACE;
		chars[11] = sgn;
		chars[12] = digit_char(temp, 100);
		chars[13] = digit_char(temp, 10);
		chars[14] = digit_char(temp, 1);
		chars[15] = CH_CR;
		for (int k = 0; k < LINE_BYTES; k++) begin
			c.ch   = chars[k];
			c.last = (k == LINE_BYTES - 1);
			line_chars_due.push_back(c);
		end
	endtask

	task automatic note_mismatch(input string what, input line_char_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s at word %0d: expected %02h last %b, got %02h last %b",
				what, words_checked, want.ch, want.last, m_tdata, m_tlast);
	endtask

	task automatic add_reading(input logic [7:0] cnt, input logic [7:0] vcode,
			input logic [7:0] tcode, input logic drain_first);
		reading_t r;
		r.data        = {tcode, vcode, cnt};
		r.drain_first = drain_first;
		readings_pending.push_back(r);
	endtask

	// Monitor: inputs and outputs are sampled at the rising edge.
	always @(posedge clk) begin
		word_in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				queue_line(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
				readings_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (line_chars_due.size() == 0) begin
					note_mismatch("unexpected word", '0);
				end else begin
					due_char = line_chars_due.pop_front();
					if (m_tdata !== due_char.ch || m_tlast !== due_char.last)
						note_mismatch("wrong word", due_char);
				end
				words_checked++;
			end
		end
	end

	// Source driver: bursts of reading sets with random gaps between them.
	always @(negedge clk) begin : source_drv
		logic        nv;
		logic [23:0] nd;
		reading_t    rd;
		if (arst_n && (!s_tvalid || word_in_taken)) begin
			nv = 1'b0;
			nd = s_tdata;
			if (gap_left > 0) begin
				gap_left--;
			end else if (readings_pending.size() > 0 &&
					!(readings_pending[0].drain_first && line_chars_due.size() != 0)) begin
				rd = readings_pending.pop_front();
				nd = rd.data;
				nv = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left--;
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
		end
	end

	// Sink: switches between always ready, random stalls and a rotating pattern,
	// with one long hold once the block has taken a few dozen reading sets.
	always @(negedge clk) begin : sink_drv
		logic rdy;
		if (arst_n) begin
			if (!long_hold_done && readings_accepted >= 40) begin
				long_hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				rx_mode    = rx_mode_t'($urandom_range(0, 2));
				mode_left  = $urandom_range(20, 200);
				rx_pattern = 8'($urandom_range(1, 255));
			end else begin
				mode_left--;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY: rdy = 1'b1;
					RX_RANDOM: rdy = ($urandom_range(0, 2) != 0);
					default: begin
						rdy        = rx_pattern[0];
						rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
					end
				endcase
			end
			m_tready <= rdy;
		end
	end

	initial begin
		#8000000;
		$display("sensor_readings_ascii_framer_unit test failed");
		$finish;
	end

	initial begin
		logic [7:0] warm_edges [5];
		logic [7:0] volt_edges [6];
		arst_n            = 1'b0;
		s_tvalid          = 1'b0;
		s_tdata           = '0;
		m_tready          = 1'b0;
		word_in_taken     = 1'b0;
		readings_accepted = 0;
		words_checked     = 0;
		mismatches        = 0;
		burst_left        = 0;
		gap_left          = 0;
		mode_left         = 0;
		long_hold_left    = 0;
		long_hold_done    = 1'b0;
		rx_mode           = RX_STEADY;
		rx_pattern        = 8'h5A;
		warm_edges        = '{8'd0, 8'd68, 8'd69, 8'd70, 8'd255};
		volt_edges        = '{8'd0, 8'd1, 8'd50, 8'd51, 8'd254, 8'd255};

		// Field extremes, digit rollovers and both sides of the temperature zero point.
		add_reading(8'd0,   8'd0,   8'd0,   1'b0);
		add_reading(8'd255, 8'd255, 8'd255, 1'b0);
		add_reading(8'd0,   8'd0,   8'd69,  1'b0);
		add_reading(8'd1,   8'd1,   8'd68,  1'b0);
		add_reading(8'd9,   8'd51,  8'd70,  1'b0);
		add_reading(8'd10,  8'd50,  8'd1,   1'b0);
		add_reading(8'd99,  8'd254, 8'd254, 1'b0);
		add_reading(8'd100, 8'd102, 8'd100, 1'b0);
		add_reading(8'd199, 8'd128, 8'd35,  1'b0);
		add_reading(8'd200, 8'd127, 8'd186, 1'b0);
		add_reading(8'd170, 8'd85,  8'd85,  1'b0);
		add_reading(8'd85,  8'd170, 8'd170, 1'b0);
		add_reading(8'd128, 8'd5,   8'd2,   1'b0);
		add_reading(8'd127, 8'd250, 8'd67,  1'b0);
		add_reading(8'd55,  8'd153, 8'd71,  1'b0);
		add_reading(8'd42,  8'd204, 8'd255, 1'b0);
		add_reading(8'd250, 8'd26,  8'd0,   1'b0);
		add_reading(8'd19,  8'd100, 8'd69,  1'b0);
		add_reading(8'd240, 8'd15,  8'd240, 1'b0);
		add_reading(8'd15,  8'd240, 8'd15,  1'b0);

		for (int i = 0; i < RANDOM_SETS; i++) begin
			// The first random set and one in the middle wait for the output to drain.
			if ($urandom_range(0, 3) == 0)
				add_reading(8'($urandom_range(0, 255)),
					volt_edges[$urandom_range(0, 5)],
					warm_edges[$urandom_range(0, 4)],
					(i == 0 || i == RANDOM_SETS / 2));
			else
				add_reading(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), (i == 0 || i == RANDOM_SETS / 2));
		end

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		while (readings_pending.size() != 0 || s_tvalid || line_chars_due.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (line_chars_due.size() != 0)
			mismatches++;

		$display("Sent %0d reading sets and checked %0d ASCII words,",
			readings_accepted, words_checked);
		$display("with source gaps, sink stalls, a long sink hold and drained pauses.");
		if (mismatches == 0) begin
			$display("sensor_readings_ascii_framer_unit test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("sensor_readings_ascii_framer_unit test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
src/sraf_pkg.sv
src/sraf_scale.sv
src/sraf_fmt.sv
src/sraf_ser.sv
src/sensor_readings_ascii_framer_unit.sv
tb/tb_sensor_readings_ascii_framer_unit.sv
